// ===== src/swrm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swrm_pkg : shared definitions for the sliding window rate meter
// Field widths, register codes, sequencer states and divider port structs.
// ----------------------------------------------------------------------------
package swrm_pkg;

  localparam int RING_DEPTH_DEF = 64;

  localparam int TIME_W  = 32;
  localparam int BYTES_W = 32;
  localparam int SUM_W   = 40;
  localparam int WIN_W   = 20;
  localparam int MIN_W   = 16;
  localparam int RATE_W  = 32;
  localparam int HELD_W  = 7;

  localparam int IN_W    = TIME_W + BYTES_W;
  localparam int OUT_W   = 40;
  localparam int OUT_PAD = OUT_W - RATE_W - HELD_W;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;

  // divider: 1000 * 40-bit sum needs 50 bits, stretched duration needs 33
  localparam int NUM_W  = 50;
  localparam int DEN_W  = 33;
  localparam int STEP_W = 6;

  localparam logic [STEP_W-1:0] SPACE_STEPS = STEP_W'(TIME_W);
  localparam logic [STEP_W-1:0] RATE_STEPS  = STEP_W'(NUM_W);

  // x * 1000 = (x << 10) - (x << 4) - (x << 3)
  localparam int MUL_SH_HI = 10;
  localparam int MUL_SH_A  = 4;
  localparam int MUL_SH_B  = 3;

  localparam logic [WIN_W-1:0] WINDOW_RESET  = 20'd40000;
  localparam logic [MIN_W-1:0] MIN_DUR_RESET = 16'd880;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW  = 2'd0,
    REG_MIN_DUR = 2'd1
  } cfg_reg_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_PREV_RD,
    S_PREV_USE,
    S_DROP,
    S_WRITE,
    S_EVICT_RD,
    S_EVICT_CHK,
    S_CALC_RD,
    S_CALC_OLD,
    S_CALC_NEW,
    S_FLOOR,
    S_ONE_IDLE,
    S_SPACE_GO,
    S_SPACE_WAIT,
    S_GAP,
    S_STRETCH,
    S_MUL_A,
    S_MUL_B,
    S_DIV_GO,
    S_DIV_WAIT,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic              start;
    logic [NUM_W-1:0]  dividend;
    logic [DEN_W-1:0]  divisor;
    logic [STEP_W-1:0] steps;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] quotient;
  } div_rsp_t;

endpackage

// ===== src/swrm_ring.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swrm_ring : entry ring storage
// Byte counts and times of the window entries, one write and one
// registered read port.
// ----------------------------------------------------------------------------
module swrm_ring #(
  parameter int DEPTH = swrm_pkg::RING_DEPTH_DEF,
  localparam int IDX_W = $clog2(DEPTH)
) (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [IDX_W-1:0]             wr_addr,
  input  logic [swrm_pkg::BYTES_W-1:0] wr_bytes,
  input  logic [swrm_pkg::TIME_W-1:0]  wr_time,
  input  logic [IDX_W-1:0]             rd_addr,
  output logic [swrm_pkg::BYTES_W-1:0] rd_bytes,
  output logic [swrm_pkg::TIME_W-1:0]  rd_time
);

  logic [swrm_pkg::BYTES_W-1:0] bytes_mem [DEPTH];
  logic [swrm_pkg::TIME_W-1:0]  time_mem  [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      bytes_mem[wr_addr] <= wr_bytes;
      time_mem[wr_addr]  <= wr_time;
    end
  end

  always_ff @(posedge clk) begin
    rd_bytes <= bytes_mem[rd_addr];
    rd_time  <= time_mem[rd_addr];
  end

endmodule

// ===== src/swrm_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swrm_div : shared bit-serial divider
// Restoring division, one quotient bit per cycle, step count per request.
// ----------------------------------------------------------------------------
module swrm_div (
  input  logic               clk,
  input  logic               rst,
  input  swrm_pkg::div_req_t req,
  output swrm_pkg::div_rsp_t rsp
);

  logic                          busy;
  logic                          done;
  logic [swrm_pkg::STEP_W-1:0]   cnt;
  logic [swrm_pkg::NUM_W-1:0]    quo;
  logic [swrm_pkg::DEN_W-1:0]    rem;
  logic [swrm_pkg::DEN_W-1:0]    divisor;
  logic [swrm_pkg::DEN_W:0]      shifted;
  logic [swrm_pkg::DEN_W:0]      trial;
  logic                          take;

  // dividend bits enter the remainder from the top of the quotient shift
  assign shifted = {rem, quo[swrm_pkg::NUM_W-1]};
  assign trial   = shifted - {1'b0, divisor};
  assign take    = !trial[swrm_pkg::DEN_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= req.steps;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == swrm_pkg::STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo     <= req.dividend;
      rem     <= '0;
      divisor <= req.divisor;
    end else if (busy) begin
      rem <= take ? trial[swrm_pkg::DEN_W-1:0] : shifted[swrm_pkg::DEN_W-1:0];
      quo <= {quo[swrm_pkg::NUM_W-2:0], take};
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    req.start |-> !busy)
    else $error("divider restarted while busy");

  a_done_after_last: assert property (@(posedge clk) disable iff (rst)
    (busy && cnt == swrm_pkg::STEP_W'(1) && !req.start) |=> (done && !busy))
    else $error("divider missed its done pulse");

endmodule

// ===== src/sliding_window_rate_meter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_rate_meter : sliding window data rate estimator
// Keeps a ring of (bytes, time) entries and reports bytes per second.
// ----------------------------------------------------------------------------
// One word is taken at a time; s_axis_tready is high only while the block
// waits for a word, and the result sits in an output register so the next
// word may be taken before it is collected. Appending to a full ring first
// drops the oldest entry, every entry dropped from the window is read and
// checked in turn, and a result still waiting in the output register holds
// the block until it is taken. The shared bit-serial divider makes one
// quotient bit per cycle: a 32-bit quotient for the mean entry spacing and
// a 50-bit quotient for the rate. The ring is a single-port-read memory, so
// entry lookups are made one at a time. Ring contents need no clearing
// after reset.
// ----------------------------------------------------------------------------
module sliding_window_rate_meter #(
  parameter int RING_DEPTH = swrm_pkg::RING_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // now_ms [31:0], added_bytes [63:32]
  input  logic [swrm_pkg::IN_W-1:0]       s_axis_tdata,
  // func [0]
  input  logic [0:0]                      s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // rate_bytes_per_s [31:0], entries_held [38:32], zero [39]
  output logic [swrm_pkg::OUT_W-1:0]      m_axis_tdata,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [swrm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [swrm_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int IDX_W = $clog2(RING_DEPTH);
  localparam int CNT_W = $clog2(RING_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(RING_DEPTH);
  localparam logic [CNT_W:0]   DEPTH_X = (CNT_W + 1)'(RING_DEPTH);

  localparam int TW = swrm_pkg::TIME_W;
  localparam int SW = swrm_pkg::SUM_W;
  localparam int DW = swrm_pkg::DEN_W;
  localparam int NW = swrm_pkg::NUM_W;

  function automatic logic [IDX_W-1:0] slot(input logic [IDX_W-1:0] base,
                                            input logic [CNT_W-1:0] off);
    logic [CNT_W:0] s;
    s = (CNT_W + 1)'(base) + (CNT_W + 1)'(off);
    if (s >= DEPTH_X) s = s - DEPTH_X;
    return s[IDX_W-1:0];
  endfunction

  swrm_pkg::state_t state, state_next;

  logic [swrm_pkg::WIN_W-1:0]  window_ms;
  logic [swrm_pkg::MIN_W-1:0]  min_duration_ms;
  logic [IDX_W-1:0]            oldest;
  logic [CNT_W-1:0]            count;
  logic [SW-1:0]               sum;
  logic [TW-1:0]               prev;

  logic [TW-1:0]               now_r;
  logic [swrm_pkg::BYTES_W-1:0] added_r;
  logic [TW-1:0]               old_time;
  logic [swrm_pkg::BYTES_W-1:0] old_bytes;
  logic [TW-1:0]               idle;
  logic [DW-1:0]               dur;
  logic [DW-1:0]               gap;
  logic [SW-1:0]               d;
  logic [NW-1:0]               numer;
  logic [swrm_pkg::RATE_W-1:0] rate;

  logic                        in_acc;
  logic                        out_free;
  logic                        multi;
  logic [CNT_W-1:0]            last_off;
  logic [IDX_W-1:0]            newest_slot;
  logic [IDX_W-1:0]            next_oldest;
  logic [IDX_W-1:0]            tail_slot;
  logic [TW-1:0]               age;
  logic                        too_old;
  logic [swrm_pkg::MIN_W-1:0]  floor_ms;
  logic [TW-1:0]               spacing;
  logic [NW-1:0]               d_ext;

  logic                        wr_en;
  logic [IDX_W-1:0]            rd_addr;
  logic [swrm_pkg::BYTES_W-1:0] rd_bytes;
  logic [TW-1:0]               rd_time;

  swrm_pkg::div_req_t          div_req;
  swrm_pkg::div_rsp_t          div_rsp;

  assign in_acc      = s_axis_tvalid && s_axis_tready;
  assign out_free    = !m_axis_tvalid || m_axis_tready;
  assign cfg_ready   = 1'b1;
  assign multi       = count > CNT_W'(1);
  assign last_off    = (count == '0) ? '0 : count - CNT_W'(1);
  assign newest_slot = slot(oldest, last_off);
  assign next_oldest = slot(oldest, CNT_W'(1));
  assign tail_slot   = slot(oldest, count);
  assign age         = prev - rd_time;
  assign too_old     = age > TW'(window_ms);
  // a zero minimum behaves as one millisecond
  assign floor_ms    = (min_duration_ms == '0) ? swrm_pkg::MIN_W'(1) : min_duration_ms;
  assign spacing     = div_rsp.quotient[TW-1:0];
  assign d_ext       = NW'(d);

  swrm_ring #(
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_addr  (tail_slot),
    .wr_bytes (added_r),
    .wr_time  (now_r),
    .rd_addr  (rd_addr),
    .rd_bytes (rd_bytes),
    .rd_time  (rd_time)
  );

  swrm_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= swrm_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next       = state;
    s_axis_tready    = 1'b0;
    rd_addr          = oldest;
    wr_en            = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = numer;
    div_req.divisor  = dur;
    div_req.steps    = swrm_pkg::RATE_STEPS;
    unique case (state)
      swrm_pkg::S_IDLE: begin
        s_axis_tready = 1'b1;
        if (in_acc) begin
          if (s_axis_tuser[0]) begin
            state_next = swrm_pkg::S_FINISH;
          end else if (s_axis_tdata[swrm_pkg::IN_W-1:TW] != '0) begin
            state_next = swrm_pkg::S_PREV_RD;
          end else begin
            state_next = swrm_pkg::S_EVICT_RD;
          end
        end
      end
      swrm_pkg::S_PREV_RD: begin
        rd_addr    = newest_slot;
        state_next = swrm_pkg::S_PREV_USE;
      end
      swrm_pkg::S_PREV_USE: begin
        // oldest entry fetched in case the ring is full
        state_next = (count == DEPTH_C) ? swrm_pkg::S_DROP : swrm_pkg::S_WRITE;
      end
      swrm_pkg::S_DROP: begin
        state_next = swrm_pkg::S_WRITE;
      end
      swrm_pkg::S_WRITE: begin
        wr_en      = 1'b1;
        state_next = swrm_pkg::S_EVICT_RD;
      end
      swrm_pkg::S_EVICT_RD: begin
        state_next = multi ? swrm_pkg::S_EVICT_CHK : swrm_pkg::S_CALC_RD;
      end
      swrm_pkg::S_EVICT_CHK: begin
        state_next = too_old ? swrm_pkg::S_EVICT_RD : swrm_pkg::S_CALC_RD;
      end
      swrm_pkg::S_CALC_RD: begin
        state_next = (count == '0) ? swrm_pkg::S_FINISH : swrm_pkg::S_CALC_OLD;
      end
      swrm_pkg::S_CALC_OLD: begin
        rd_addr    = newest_slot;
        state_next = swrm_pkg::S_CALC_NEW;
      end
      swrm_pkg::S_CALC_NEW: begin
        state_next = swrm_pkg::S_FLOOR;
      end
      swrm_pkg::S_FLOOR: begin
        state_next = multi ? swrm_pkg::S_SPACE_GO : swrm_pkg::S_ONE_IDLE;
      end
      swrm_pkg::S_ONE_IDLE: begin
        state_next = swrm_pkg::S_MUL_A;
      end
      swrm_pkg::S_SPACE_GO: begin
        // duration placed at the top of the dividend, quotient lands low
        div_req.start    = 1'b1;
        div_req.dividend = {dur[TW-1:0], {(NW - TW){1'b0}}};
        div_req.divisor  = DW'(count - CNT_W'(1));
        div_req.steps    = swrm_pkg::SPACE_STEPS;
        state_next       = swrm_pkg::S_SPACE_WAIT;
      end
      swrm_pkg::S_SPACE_WAIT: begin
        if (div_rsp.done) state_next = swrm_pkg::S_GAP;
      end
      swrm_pkg::S_GAP: begin
        state_next = swrm_pkg::S_STRETCH;
      end
      swrm_pkg::S_STRETCH: begin
        state_next = swrm_pkg::S_MUL_A;
      end
      swrm_pkg::S_MUL_A: begin
        state_next = swrm_pkg::S_MUL_B;
      end
      swrm_pkg::S_MUL_B: begin
        state_next = swrm_pkg::S_DIV_GO;
      end
      swrm_pkg::S_DIV_GO: begin
        div_req.start = 1'b1;
        state_next    = swrm_pkg::S_DIV_WAIT;
      end
      swrm_pkg::S_DIV_WAIT: begin
        if (div_rsp.done) state_next = swrm_pkg::S_FINISH;
      end
      swrm_pkg::S_FINISH: begin
        if (out_free) state_next = swrm_pkg::S_IDLE;
      end
      default: begin
        state_next = swrm_pkg::S_IDLE;
      end
    endcase
  end

  // window bookkeeping and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      window_ms       <= swrm_pkg::WINDOW_RESET;
      min_duration_ms <= swrm_pkg::MIN_DUR_RESET;
      oldest          <= '0;
      count           <= '0;
      sum             <= '0;
      prev            <= '0;
      m_axis_tvalid   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          swrm_pkg::REG_WINDOW:  window_ms       <= cfg_data;
          swrm_pkg::REG_MIN_DUR: min_duration_ms <= cfg_data[swrm_pkg::MIN_W-1:0];
          default: ;
        endcase
      end
      case (state)
        swrm_pkg::S_IDLE: begin
          if (in_acc && s_axis_tuser[0]) begin
            oldest <= '0;
            count  <= '0;
            sum    <= '0;
          end
        end
        swrm_pkg::S_PREV_USE: begin
          if (count != '0) prev <= rd_time;
        end
        swrm_pkg::S_DROP: begin
          sum    <= sum - SW'(rd_bytes);
          oldest <= next_oldest;
          count  <= count - CNT_W'(1);
        end
        swrm_pkg::S_WRITE: begin
          count <= count + CNT_W'(1);
          sum   <= sum + SW'(added_r);
        end
        swrm_pkg::S_EVICT_CHK: begin
          if (too_old) begin
            sum    <= sum - SW'(rd_bytes);
            oldest <= next_oldest;
            count  <= count - CNT_W'(1);
          end
        end
        default: ;
      endcase
      if (state == swrm_pkg::S_FINISH && out_free) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // rate datapath
  always_ff @(posedge clk) begin
    case (state)
      swrm_pkg::S_IDLE: begin
        if (in_acc) begin
          now_r   <= s_axis_tdata[TW-1:0];
          added_r <= s_axis_tdata[swrm_pkg::IN_W-1:TW];
          rate    <= '0;
        end
      end
      swrm_pkg::S_CALC_OLD: begin
        old_time  <= rd_time;
        old_bytes <= rd_bytes;
      end
      swrm_pkg::S_CALC_NEW: begin
        // single entry measures from the previous newest time, span wraps at 32 bits
        dur  <= {{(DW - TW){1'b0}}, rd_time - (multi ? old_time : prev)};
        idle <= now_r - rd_time;
      end
      swrm_pkg::S_FLOOR: begin
        if (dur < DW'(floor_ms)) dur <= DW'(floor_ms);
        d <= multi ? sum - SW'(old_bytes) : sum;
      end
      swrm_pkg::S_ONE_IDLE: begin
        if (DW'(idle) > dur) dur <= DW'(idle);
      end
      swrm_pkg::S_GAP: begin
        gap <= (idle > spacing) ? DW'(idle - spacing) : '0;
      end
      swrm_pkg::S_STRETCH: begin
        dur <= dur + gap;
      end
      swrm_pkg::S_MUL_A: begin
        numer <= (d_ext << swrm_pkg::MUL_SH_HI) - (d_ext << swrm_pkg::MUL_SH_B);
      end
      swrm_pkg::S_MUL_B: begin
        numer <= numer - (d_ext << swrm_pkg::MUL_SH_A);
      end
      swrm_pkg::S_DIV_WAIT: begin
        if (div_rsp.done) begin
          rate <= (div_rsp.quotient[NW-1:swrm_pkg::RATE_W] != '0)
                  ? '1 : div_rsp.quotient[swrm_pkg::RATE_W-1:0];
        end
      end
      swrm_pkg::S_FINISH: begin
        if (out_free) begin
          m_axis_tdata <= {{swrm_pkg::OUT_PAD{1'b0}}, swrm_pkg::HELD_W'(count), rate};
        end
      end
      default: ;
    endcase
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= DEPTH_C)
    else $error("entry count beyond ring depth");

  a_write_room: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> count < DEPTH_C)
    else $error("append into a full ring");

  a_clear_result: assert property (@(posedge clk) disable iff (rst)
    (state == swrm_pkg::S_IDLE && in_acc && s_axis_tuser[0]) |=>
      (count == '0 && rate == '0 && state == swrm_pkg::S_FINISH))
    else $error("clear word left window state behind");

  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> div_req.divisor != '0)
    else $error("divider started with zero divisor");

endmodule
